### rtl/sac_pkg.sv
// ---------------------------------------------------------------------------
// sac_pkg
// Sizes, line layout, register indexes and cost constants of the
// set-associative cache controller.
// ---------------------------------------------------------------------------
package sac_pkg;

  localparam int SETS     = 256;
  localparam int WAYS     = 8;
  localparam int TAG_BITS = 24;

  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NWAY_W  = $clog2(WAYS + 1);
  localparam int TREE_LV = (WAYS > 1) ? $clog2(WAYS) : 0;
  localparam int TREE_N  = 1 << TREE_LV;

  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int TOT_W   = 64;
  localparam int COST_W  = 18;
  localparam int BC_W    = 17;

  // input field widths
  localparam int TAG_FIELD_W = 24;
  localparam int SET_FIELD_W = 8;
  localparam int IN_W        = TAG_FIELD_W + SET_FIELD_W;

  // result: hit, dirty_eviction, cycles_added, four counters, total
  localparam int OUT_BITS = 2 + COST_W + 4 * CNT_W + TOT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALLOC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WBACK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LRU    = 3'd4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  // statistics counter slots, index is {kind, miss}
  localparam logic [1:0] CNT_LOAD_HIT   = 2'd0;
  localparam logic [1:0] CNT_LOAD_MISS  = 2'd1;
  localparam logic [1:0] CNT_STORE_HIT  = 2'd2;
  localparam logic [1:0] CNT_STORE_MISS = 2'd3;

  // memory cost model
  localparam int COST_UNIT  = 100;
  localparam int WORD_BYTES = 4;
  localparam int BLK_MIN    = 4;
  localparam int BLK_MAX    = 4096;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [TAG_BITS-1:0] tag;
    logic [STAMP_W-1:0]  acc;
    logic [STAMP_W-1:0]  fill;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

### rtl/sac_ram.sv
// ---------------------------------------------------------------------------
// sac_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/set_assoc_cache_controller.sv
// ---------------------------------------------------------------------------
// set_assoc_cache_controller
// Set-associative cache tag/statistics engine: one access per transaction,
// LRU or FIFO replacement, write-back or write-through, running totals.
// ---------------------------------------------------------------------------
//  channel  | dir | payload
//  s_*      | in  | tuser: kind; tdata: tag, set_index
//  m_*      | out | tdata: hit, dirty_eviction, cycles_added, load hit count,
//           |     |        load miss count, store hit count, store miss count,
//           |     |        cycle total
//  cfg_*    | in  | cfg_index selects register, cfg_data is the value
//
//  Each access reads its set row from the RAM on acceptance, then does lookup
//  and victim choice in the lookup state and writes the row back in the
//  update state; a new transaction is taken in the write-back cycle, so
//  accesses overlap there. The result is registered on write-back.
//  Reset clears a per-set flag; a set never written reads as all invalid,
//  so there is no clearing pass over the RAM.
//  The write-back cycle holds while the output register is still full.
// ---------------------------------------------------------------------------
module set_assoc_cache_controller
  import sac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // tag[23:0], set_index[31:24]
  input  logic [0:0]            s_tuser,   // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata    // hit, dirty_eviction, cycles_added,
                                           // load hit count, load miss count,
                                           // store hit count, store miss count,
                                           // cycle total, zero pad
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state, state_next;

  // configuration
  logic [3:0]            cfg_ways;
  logic [CFG_DATA_W-1:0] cfg_block;
  logic                  cfg_walloc, cfg_wb, cfg_lru;

  // request
  logic                  kind_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [SET_W-1:0]      set_q;
  logic                  fwd_q;
  row_t                  wrow_q;
  logic [SETS-1:0]       touched;

  // lookup results
  logic                  hit_q, any_inv_q;
  logic [WAY_W-1:0]      sel_q;
  row_t                  row_q;
  logic [BC_W-1:0]       bc_q;

  // statistics
  logic [CNT_W-1:0]      cnt [0:3];
  logic [TOT_W-1:0]      total;
  logic [STAMP_W-1:0]    stamp;
  logic [OUT_W-1:0]      out_data;

  logic                  in_fire, upd_fire;
  logic [ROW_W-1:0]      ram_rdata;

  assign upd_fire = (state == ST_UPD) && (!m_tvalid || m_tready);
  assign s_tready = (state == ST_IDLE) || upd_fire;
  assign in_fire  = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_LOOK;
      ST_LOOK: state_next = ST_UPD;
      ST_UPD: begin
        if (upd_fire) state_next = in_fire ? ST_LOOK : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_ways   <= 4'd8;
      cfg_block  <= 13'd16;
      cfg_walloc <= 1'b1;
      cfg_wb     <= 1'b1;
      cfg_lru    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WAYS:   cfg_ways   <= cfg_data[3:0];
        REG_BLOCK:  cfg_block  <= cfg_data;
        REG_WALLOC: cfg_walloc <= cfg_data[0];
        REG_WBACK:  cfg_wb     <= cfg_data[0];
        REG_LRU:    cfg_lru    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Lookup cycle
  // -------------------------------------------------------------------------
  row_t                  rd_row;
  logic [NWAY_W-1:0]     nways;
  logic [WAYS-1:0]       in_use, hit_vec, inv_vec;
  logic [WAY_W-1:0]      hit_way, inv_way, vic_way, sel_c;
  logic [CFG_DATA_W-1:0] bb;
  logic [BC_W-1:0]       bc_c;

  logic [STAMP_W-1:0]    t_s  [0:TREE_LV][0:TREE_N-1];
  logic                  t_ok [0:TREE_LV][0:TREE_N-1];
  logic [WAY_W-1:0]      t_w  [0:TREE_LV][0:TREE_N-1];

  always_comb begin
    // a row written in the previous cycle has not reached the RAM output
    if (fwd_q) rd_row = wrow_q;
    else if (touched[set_q]) rd_row = row_t'(ram_rdata);
    else rd_row = '0;

    if (cfg_ways == '0) nways = NWAY_W'(1);
    else if (32'(cfg_ways) > 32'(WAYS)) nways = NWAY_W'(WAYS);
    else nways = NWAY_W'(cfg_ways);

    hit_way = '0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      in_use[w]  = NWAY_W'(w) < nways;
      hit_vec[w] = in_use[w] && rd_row[w].valid && (rd_row[w].tag == tag_q);
      inv_vec[w] = in_use[w] && !rd_row[w].valid;
      if (hit_vec[w]) hit_way = WAY_W'(w);
      if (inv_vec[w]) inv_way = WAY_W'(w);
    end

    // min tree over the replacement stamps; ties keep the lower way
    for (int l = 0; l <= TREE_LV; l++) begin
      for (int i = 0; i < TREE_N; i++) begin
        t_s[l][i]  = '0;
        t_ok[l][i] = 1'b0;
        t_w[l][i]  = '0;
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      t_s[0][i]  = cfg_lru ? rd_row[i].acc : rd_row[i].fill;
      t_ok[0][i] = in_use[i];
      t_w[0][i]  = WAY_W'(i);
    end
    for (int l = 0; l < TREE_LV; l++) begin
      for (int i = 0; i < TREE_N / 2; i++) begin
        if (i < (TREE_N >> (l + 1))) begin
          if (t_ok[l][2*i+1] && (!t_ok[l][2*i] || (t_s[l][2*i+1] < t_s[l][2*i]))) begin
            t_s[l+1][i] = t_s[l][2*i+1];
            t_w[l+1][i] = t_w[l][2*i+1];
          end else begin
            t_s[l+1][i] = t_s[l][2*i];
            t_w[l+1][i] = t_w[l][2*i];
          end
          t_ok[l+1][i] = t_ok[l][2*i] || t_ok[l][2*i+1];
        end
      end
    end
    vic_way = t_w[TREE_LV][0];

    if (|hit_vec) sel_c = hit_way;
    else if (|inv_vec) sel_c = inv_way;
    else sel_c = vic_way;

    if (cfg_block < CFG_DATA_W'(BLK_MIN)) bb = CFG_DATA_W'(BLK_MIN);
    else if (cfg_block > CFG_DATA_W'(BLK_MAX)) bb = CFG_DATA_W'(BLK_MAX);
    else bb = cfg_block;
    bc_c = BC_W'(bb / CFG_DATA_W'(WORD_BYTES)) * BC_W'(COST_UNIT);
  end

  // -------------------------------------------------------------------------
  // Update cycle
  // -------------------------------------------------------------------------
  logic              alloc, dev;
  logic [COST_W-1:0] cost, bc_x, wr_cost;
  row_t              row_new;
  logic [1:0]        slot;
  logic [CNT_W-1:0]  cnt_new [0:3];
  logic [TOT_W:0]    tot_sum;
  logic [TOT_W-1:0]  tot_new;

  always_comb begin
    alloc   = !hit_q && ((kind_q == KIND_LOAD) || cfg_walloc);
    dev     = alloc && !any_inv_q && row_q[sel_q].dirty;
    bc_x    = COST_W'(bc_q);
    wr_cost = cfg_wb ? COST_W'(1) : COST_W'(COST_UNIT + 1);

    if (kind_q == KIND_LOAD) cost = hit_q ? COST_W'(1) : bc_x + COST_W'(1);
    else if (hit_q) cost = wr_cost;
    else if (alloc) cost = bc_x + wr_cost;
    else cost = COST_W'(COST_UNIT);
    if (dev) cost = cost + bc_x;

    row_new = row_q;
    if (hit_q) begin
      row_new[sel_q].acc = stamp;
      if ((kind_q == KIND_STORE) && cfg_wb) row_new[sel_q].dirty = 1'b1;
    end else if (alloc) begin
      row_new[sel_q].valid = 1'b1;
      row_new[sel_q].dirty = (kind_q == KIND_STORE) && cfg_wb;
      row_new[sel_q].tag   = tag_q;
      row_new[sel_q].acc   = stamp;
      row_new[sel_q].fill  = stamp;
    end

    slot = {kind_q, !hit_q};
    for (int i = 0; i < 4; i++) begin
      cnt_new[i] = cnt[i];
    end
    if (cnt[slot] != '1) cnt_new[slot] = cnt[slot] + CNT_W'(1);

    tot_sum = {1'b0, total} + (TOT_W + 1)'(cost);
    tot_new = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
  end

  sac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk   (clk),
    .we    (upd_fire),
    .waddr (set_q),
    .wdata (row_new),
    .re    (in_fire),
    .raddr (s_tdata[TAG_FIELD_W +: SET_W]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q <= s_tuser[0];
      tag_q  <= s_tdata[TAG_BITS-1:0];
      set_q  <= s_tdata[TAG_FIELD_W +: SET_W];
    end
    if (state == ST_LOOK) begin
      hit_q     <= |hit_vec;
      any_inv_q <= |inv_vec;
      sel_q     <= sel_c;
      row_q     <= rd_row;
      bc_q      <= bc_c;
    end
    if (upd_fire) begin
      wrow_q   <= row_new;
      out_data <= OUT_W'({tot_new, cnt_new[CNT_STORE_MISS], cnt_new[CNT_STORE_HIT],
                          cnt_new[CNT_LOAD_MISS], cnt_new[CNT_LOAD_HIT],
                          cost, dev, hit_q});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_q    <= 1'b0;
      touched  <= '0;
      stamp    <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      if (in_fire) begin
        fwd_q <= upd_fire && (s_tdata[TAG_FIELD_W +: SET_W] == set_q);
      end
      if (upd_fire) begin
        touched[set_q] <= 1'b1;
        stamp          <= stamp + STAMP_W'(1);
        total          <= tot_new;
        for (int i = 0; i < 4; i++) begin
          cnt[i] <= cnt_new[i];
        end
      end
      if (upd_fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = out_data;

`ifndef NO_ASSERTIONS
  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_LOOK))
    else $error("accepted transaction did not move to lookup");

  a_no_accept_in_look: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |-> !s_tready)
    else $error("input taken during lookup");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_LOOK) && fwd_q) |-> $past(upd_fire))
    else $error("forwarded row without a preceding write");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_UPD))
    else $error("result raised outside update cycle");

  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (total >= $past(total)))
    else $error("cycle total decreased");
`endif

endmodule
